// File: rtl/record_exchange_sorter_assert.svh
// Assertion macros for the sorter RTL.
// Each macro checks a property on the rising clock edge and is disabled in reset.
`ifndef RECORD_EXCHANGE_SORTER_ASSERT_SVH
`define RECORD_EXCHANGE_SORTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RXS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define RXS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: rtl/rxsort_pkg.sv
package rxsort_pkg;

  // Field widths of one record.
  localparam int KEY_HIGH_W = 48;
  localparam int KEY_LOW_W  = 32;
  localparam int KEY_W      = KEY_HIGH_W + KEY_LOW_W;
  localparam int TAG_W      = 16;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // One stored record: the key compares as an unsigned number.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } rxsort_word_t;

  // One classified transaction as it travels through the queue.
  typedef struct packed {
    rxsort_word_t word;
    logic         keep;
    logic         last;
  } rxsort_rec_t;

  // Phase of the back end, seen by the top level.
  typedef struct packed {
    logic loading;
    logic emitting;
  } rxsort_stat_t;

endpackage

// File: rtl/rxsort_front.sv
module rxsort_front import rxsort_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KEY_HIGH_W-1:0] in_key_high,
  input  logic [KEY_LOW_W-1:0]  in_key_low,
  input  logic [TAG_W-1:0]      in_tag,
  input  logic                  in_last_in,
  input  logic                  q_full,
  output logic                  q_push,
  output rxsort_rec_t           q_rec
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             keep;

  // The front takes a transaction whenever the queue has room.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // A record is kept while the batch still fits into the store.
  assign keep = (cnt_r < CNT_W'(CAPACITY));

  always_comb begin
    q_rec.word.key = {in_key_high, in_key_low};
    q_rec.word.tag = in_tag;
    q_rec.keep     = keep;
    q_rec.last     = in_last_in;
  end

  // Count the records of the current batch; the last one restarts the count.
  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_last_in) begin
        cnt_nxt = '0;
      end else if (keep) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/rxsort_queue.sv
module rxsort_queue import rxsort_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  rxsort_rec_t push_rec,
  output logic        full,
  input  logic        pop,
  output logic        head_valid,
  output rxsort_rec_t head_rec
);

  rxsort_rec_t       slot_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r;
  logic [QPTR_W-1:0] rp_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_rec   = slot_r[rp_r];
  assign do_pop     = pop && head_valid;

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= wp_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rp_r <= rp_r + QPTR_W'(1);
      end
    end
  end

  // Slot storage carries no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_rec;
    end
  end

endmodule

// File: rtl/rxsort_back.sv
module rxsort_back import rxsort_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  rxsort_rec_t           q_rec,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KEY_HIGH_W-1:0] out_sorted_key_high,
  output logic [KEY_LOW_W-1:0]  out_sorted_key_low,
  output logic [TAG_W-1:0]      out_sorted_tag,
  output logic                  out_last_out,
  output logic                  out_dropped,
  output rxsort_stat_t          stat
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = $clog2(CAPACITY);

  localparam logic [3:0] ST_LOAD   = 4'd0;
  localparam logic [3:0] ST_START  = 4'd1;
  localparam logic [3:0] ST_RDI    = 4'd2;
  localparam logic [3:0] ST_GETI   = 4'd3;
  localparam logic [3:0] ST_SCAN   = 4'd4;
  localparam logic [3:0] ST_WRI    = 4'd5;
  localparam logic [3:0] ST_EMRD   = 4'd6;
  localparam logic [3:0] ST_EMLD   = 4'd7;
  localparam logic [3:0] ST_EMWAIT = 4'd8;

  rxsort_word_t      mem [CAPACITY];
  rxsort_word_t      rd_data_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  rxsort_word_t      wr_data;

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;
  logic [ADDR_W-1:0] k_r, k_nxt;
  rxsort_word_t      cur_r, cur_nxt;
  logic              out_valid_r, out_valid_nxt;
  rxsort_word_t      out_word_r;
  logic              out_last_r;
  logic              out_drop_r;
  logic              load_out;
  logic              cur_greater;

  // The held record moves down whenever a later key is smaller.
  assign cur_greater = (cur_r.key > rd_data_r.key);

  // Sequencer: load batch, interchange sort, then emit in order.
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;
    rd_addr       = k_r;
    wr_en         = 1'b0;
    wr_addr       = fill_r[ADDR_W-1:0];
    wr_data       = q_rec.word;
    load_out      = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_rec.keep) begin
            wr_en    = 1'b1;
            fill_nxt = fill_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (q_rec.last) begin
            state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        i_nxt = '0;
        k_nxt = '0;
        if (fill_r > CNT_W'(1)) begin
          state_nxt = ST_RDI;
        end else begin
          state_nxt = ST_EMRD;
        end
      end
      ST_RDI: begin
        rd_addr   = i_r;
        state_nxt = ST_GETI;
      end
      ST_GETI: begin
        cur_nxt   = rd_data_r;
        rd_addr   = i_r + ADDR_W'(1);
        j_nxt     = i_r + ADDR_W'(1);
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (cur_greater) begin
          wr_en   = 1'b1;
          wr_addr = j_r;
          wr_data = cur_r;
          cur_nxt = rd_data_r;
        end
        if (CNT_W'(j_r) + CNT_W'(1) < fill_r) begin
          rd_addr = j_r + ADDR_W'(1);
          j_nxt   = j_r + ADDR_W'(1);
        end else begin
          state_nxt = ST_WRI;
        end
      end
      ST_WRI: begin
        wr_en   = 1'b1;
        wr_addr = i_r;
        wr_data = cur_r;
        if (CNT_W'(i_r) + CNT_W'(2) < fill_r) begin
          i_nxt     = i_r + ADDR_W'(1);
          state_nxt = ST_RDI;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_EMRD;
        end
      end
      ST_EMRD: begin
        rd_addr   = k_r;
        state_nxt = ST_EMLD;
      end
      ST_EMLD: begin
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_EMWAIT;
      end
      ST_EMWAIT: begin
        if (out_valid_r && !out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            fill_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            k_nxt     = k_r + ADDR_W'(1);
            state_nxt = ST_EMRD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Index, held record and output payload registers.
  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    cur_r <= cur_nxt;
    if (load_out) begin
      out_word_r <= rd_data_r;
      out_last_r <= (CNT_W'(k_r) + CNT_W'(1) == fill_r);
      out_drop_r <= ovf_r;
    end
  end

  // Record store with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid           = out_valid_r;
  assign out_sorted_key_high = out_word_r.key[KEY_W-1:KEY_LOW_W];
  assign out_sorted_key_low  = out_word_r.key[KEY_LOW_W-1:0];
  assign out_sorted_tag      = out_word_r.tag;
  assign out_last_out        = out_last_r;
  assign out_dropped         = out_drop_r;

  assign stat.loading  = (state_r == ST_LOAD);
  assign stat.emitting = (state_r == ST_EMLD) || (state_r == ST_EMWAIT)
                         || (state_r == ST_EMRD);

endmodule

// File: rtl/record_exchange_sorter.sv
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   key_high, key_low, tag, last_in
// out_      output     out_valid/out_stall sorted_key_high, sorted_key_low, sorted_tag,
//                                          last_out, dropped
//
// The front takes one transaction per cycle into a four-entry queue while it has room.
// A batch of n records is sorted with one key compare per cycle in the scan state, set
// by the single read port of the record store. Each result then passes through the read,
// load and wait states, plus any output stall. Reset is synchronous and clears control
// state only; the record store is not cleared. Either side may stall without loss.
module record_exchange_sorter import rxsort_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KEY_HIGH_W-1:0] in_key_high,
  input  logic [KEY_LOW_W-1:0]  in_key_low,
  input  logic [TAG_W-1:0]      in_tag,
  input  logic                  in_last_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KEY_HIGH_W-1:0] out_sorted_key_high,
  output logic [KEY_LOW_W-1:0]  out_sorted_key_low,
  output logic [TAG_W-1:0]      out_sorted_tag,
  output logic                  out_last_out,
  output logic                  out_dropped
);

`include "record_exchange_sorter_assert.svh"

  logic         q_full;
  logic         q_push;
  rxsort_rec_t  q_push_rec;
  logic         q_pop;
  logic         q_valid;
  rxsort_rec_t  q_head_rec;
  rxsort_stat_t back_stat;

  // Front: accept and classify each record.
  rxsort_front #(.CAPACITY(CAPACITY)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_key_high (in_key_high),
    .in_key_low  (in_key_low),
    .in_tag      (in_tag),
    .in_last_in  (in_last_in),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_rec       (q_push_rec)
  );

  // Queue between the front and the back.
  rxsort_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_rec   (q_push_rec),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_rec   (q_head_rec)
  );

  // Back: store, sort and emit the batch.
  rxsort_back #(.CAPACITY(CAPACITY)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_rec               (q_head_rec),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_sorted_key_high (out_sorted_key_high),
    .out_sorted_key_low  (out_sorted_key_low),
    .out_sorted_tag      (out_sorted_tag),
    .out_last_out        (out_last_out),
    .out_dropped         (out_dropped),
    .stat                (back_stat)
  );

  // Results appear only in the emit phase, and the queue drains only while loading.
  `RXS_ASSERT_SAME(a_out_in_emit, clk, rst_n, out_valid, back_stat.emitting)
  `RXS_ASSERT_SAME(a_pop_in_load, clk, rst_n, q_pop, back_stat.loading && q_valid)
  // The back returns to loading right after the final result of a batch leaves.
  `RXS_ASSERT_NEXT(a_last_reload, clk, rst_n, out_valid && !out_stall && out_last_out,
                   back_stat.loading && !out_valid)

endmodule
